>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL modules; nonce_replay_guard is the one that uses them.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NRG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define NRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/nrg_pkg.sv
// Package for the nonce replay guard: sizes, item types, codes, ring helpers.
// No dependencies.
`timescale 1ns / 1ps

package nrg_pkg;

    localparam int SESSIONS    = 16;
    localparam int NONCE_DEPTH = 16;
    localparam int NONCE_BITS  = 64;
    localparam int TIME_BITS   = 48;

    localparam int CFG_TIME_W  = 48;
    localparam int CFG_LIM_W   = 5;
    localparam int CFG_IDX_W   = 2;

    localparam int SESS_W  = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int HEAD_W  = (NONCE_DEPTH > 1) ? $clog2(NONCE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(NONCE_DEPTH + 1);
    localparam int SUM_W   = COUNT_W + 1;
    localparam int ADDR_W  = SESS_W + HEAD_W;
    localparam int MEM_DEPTH = SESSIONS * (1 << HEAD_W);
    localparam int CMP_W   = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;

    typedef logic [TIME_BITS-1:0]  tm_t;
    typedef logic [NONCE_BITS-1:0] nval_t;
    typedef logic [HEAD_W-1:0]     head_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [SESS_W-1:0]     sess_t;
    typedef logic [ADDR_W-1:0]     addr_t;

    localparam logic REQ_CHECK = 1'b0;
    localparam logic REQ_RESET = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SKEW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NONC = 2'd2;

    typedef enum logic [2:0] {
        DEC_OK      = 3'd0,
        DEC_INVALID = 3'd1,
        DEC_FUTURE  = 3'd2,
        DEC_EXPIRED = 3'd3,
        DEC_DUP     = 3'd4
    } dec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_PRUNE,
        S_SEARCH,
        S_APPEND,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  session_index;
        logic [63:0] nonce;
        logic [47:0] issued_ms;
        logic [47:0] now_ms;
    } req_item_t;

    typedef struct packed {
        logic       accepted;
        logic [2:0] decision;
    } rsp_item_t;

    // Position off entries after head, wrapped; off never exceeds the depth.
    function automatic head_t ring_pos(head_t head, logic [SUM_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + off;
        if (sum >= SUM_W'(NONCE_DEPTH))
            sum = sum - SUM_W'(NONCE_DEPTH);
        return HEAD_W'(sum);
    endfunction

    // Strictly older than now by more than age; no wraparound.
    function automatic logic is_late(tm_t now, tm_t t, logic [CFG_TIME_W-1:0] age);
        tm_t diff;
        diff = now - t;
        return (now > t) && (CMP_W'(diff) > CMP_W'(age));
    endfunction

endpackage

>>> rtl/core/nonce_replay_guard.sv
// Nonce replay guard: one request at a time, per-session rings in block RAM.
// An accepted request goes to PRE; a reset or rejected one then goes to FINISH, an empty
// ring to APPEND, else PRUNE drops expired oldest entries, SEARCH scans the rest and APPEND
// adds the new entry before FINISH; a ring pruned empty skips SEARCH; a duplicate ends it.
// Throughput: a new item waits for the result to load; one entry per cycle in prune, search.
// Reset clears control state, configuration and all ring counts; RAM is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nonce_replay_guard
    import nrg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_TIME_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_item_t             req_item,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_item_t             rsp_item
);

    state_t state_reg, state_next;

    logic [CFG_TIME_W-1:0] max_age_reg, max_skew_reg;
    logic [CFG_LIM_W-1:0]  max_nonc_reg;

    head_t  ring_head_reg  [SESSIONS];
    count_t ring_count_reg [SESSIONS];

    req_item_t item_reg;
    sess_t     sess_reg, sess_next;
    logic      sess_ok;
    head_t     work_head_reg, work_head_next;
    count_t    work_count_reg, work_count_next;
    count_t    idx_reg, idx_next;
    logic      pend_reg, pend_next;
    logic      wb_reg, wb_next;
    dec_t      dec_reg, dec_next;

    logic      rsp_valid_reg, rsp_valid_next;
    rsp_item_t rsp_item_reg;
    logic      rsp_load;

    // ring storage
    nval_t nonce_mem [MEM_DEPTH];
    tm_t   stamp_mem [MEM_DEPTH];
    addr_t rd_addr, wr_addr;
    logic  wr_en;
    nval_t rd_nonce_reg;
    tm_t   rd_stamp_reg;

    nval_t  nonce_v;
    tm_t    created_v, now_v, fut_diff;
    count_t lim;
    logic   stamp_late;

    head_t            slot, head1;
    logic [SUM_W-1:0] count1;

    assign nonce_v   = NONCE_BITS'(item_reg.nonce);
    assign created_v = TIME_BITS'(item_reg.issued_ms);
    assign now_v     = TIME_BITS'(item_reg.now_ms);
    assign fut_diff  = created_v - now_v;
    assign sess_ok   = 32'(req_item.session_index) < 32'(SESSIONS);

    assign lim = (32'(max_nonc_reg) > 32'(NONCE_DEPTH)) ? COUNT_W'(NONCE_DEPTH)
                                                        : COUNT_W'(max_nonc_reg);

    assign stamp_late = is_late(now_v, rd_stamp_reg, max_age_reg);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_load  = (state_reg == S_FINISH) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // append: new entry after the tail; a full ring overwrites its oldest
    assign slot = ring_pos(work_head_reg, SUM_W'(work_count_reg));
    always_comb
    begin
        if (32'(work_count_reg) == 32'(NONCE_DEPTH))
        begin
            head1  = ring_pos(work_head_reg, SUM_W'(1));
            count1 = SUM_W'(work_count_reg);
        end
        else
        begin
            head1  = work_head_reg;
            count1 = SUM_W'(work_count_reg) + SUM_W'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_PRE;
            end
            S_PRE:
            begin
                if (!wb_reg || item_reg.req_type == REQ_RESET)
                    state_next = S_FINISH;
                else if (nonce_v == '0 || created_v == '0 || max_age_reg == '0 ||
                         max_nonc_reg == '0)
                    state_next = S_FINISH;
                else if (created_v > now_v && CMP_W'(fut_diff) > CMP_W'(max_skew_reg))
                    state_next = S_FINISH;
                else if (is_late(now_v, created_v, max_age_reg))
                    state_next = S_FINISH;
                else if (ring_count_reg[sess_reg] == '0)
                    state_next = S_APPEND;
                else
                    state_next = S_PRUNE;
            end
            S_PRUNE:
            begin
                if (stamp_late)
                begin
                    if (work_count_reg == COUNT_W'(1))
                        state_next = S_APPEND;
                end
                else
                    state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (pend_reg && rd_nonce_reg == nonce_v)
                    state_next = S_FINISH;
                else if (idx_reg >= work_count_reg)
                    state_next = S_APPEND;
            end
            S_APPEND:
                state_next = S_FINISH;
            S_FINISH:
            begin
                if (rsp_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        sess_next       = sess_reg;
        work_head_next  = work_head_reg;
        work_count_next = work_count_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        wb_next         = wb_reg;
        dec_next        = dec_reg;
        rd_addr         = {sess_reg, work_head_reg};
        wr_addr         = {sess_reg, slot};
        wr_en           = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                sess_next = sess_ok ? SESS_W'(req_item.session_index) : '0;
                wb_next   = sess_ok;
            end
            S_PRE:
            begin
                work_head_next  = ring_head_reg[sess_reg];
                work_count_next = ring_count_reg[sess_reg];
                rd_addr         = {sess_reg, ring_head_reg[sess_reg]};
                dec_next        = DEC_OK;
                if (!wb_reg)
                    dec_next = DEC_INVALID;
                else if (item_reg.req_type == REQ_RESET)
                begin
                    work_head_next  = '0;
                    work_count_next = '0;
                end
                else if (nonce_v == '0 || created_v == '0 || max_age_reg == '0 ||
                         max_nonc_reg == '0)
                begin
                    dec_next = DEC_INVALID;
                    wb_next  = 1'b0;
                end
                else if (created_v > now_v && CMP_W'(fut_diff) > CMP_W'(max_skew_reg))
                begin
                    dec_next = DEC_FUTURE;
                    wb_next  = 1'b0;
                end
                else if (is_late(now_v, created_v, max_age_reg))
                begin
                    dec_next = DEC_EXPIRED;
                    wb_next  = 1'b0;
                end
            end
            S_PRUNE:
            begin
                // read data belongs to the current oldest entry
                if (stamp_late)
                begin
                    work_head_next  = ring_pos(work_head_reg, SUM_W'(1));
                    work_count_next = work_count_reg - COUNT_W'(1);
                    rd_addr         = {sess_reg, ring_pos(work_head_reg, SUM_W'(1))};
                end
                idx_next = '0;
            end
            S_SEARCH:
            begin
                if (pend_reg && rd_nonce_reg == nonce_v)
                    dec_next = DEC_DUP;
                else if (idx_reg < work_count_reg)
                begin
                    rd_addr   = {sess_reg, ring_pos(work_head_reg, SUM_W'(idx_reg))};
                    idx_next  = idx_reg + COUNT_W'(1);
                    pend_next = 1'b1;
                end
            end
            S_APPEND:
            begin
                wr_en = 1'b1;
                if (count1 > SUM_W'(lim))
                begin
                    work_head_next  = ring_pos(head1, count1 - SUM_W'(lim));
                    work_count_next = lim;
                end
                else
                begin
                    work_head_next  = head1;
                    work_count_next = COUNT_W'(count1);
                end
            end
            S_FINISH:
            begin
            end
            default:
            begin
            end
        endcase

        if (rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            max_age_reg   <= '0;
            max_skew_reg  <= '0;
            max_nonc_reg  <= '0;
            pend_reg      <= 1'b0;
            wb_reg        <= 1'b0;
            for (int s = 0; s < SESSIONS; s++)
            begin
                ring_head_reg[s]  <= '0;
                ring_count_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            pend_reg      <= pend_next;
            wb_reg        <= wb_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_AGE:  max_age_reg  <= cfg_data;
                    CFG_MAX_SKEW: max_skew_reg <= cfg_data;
                    CFG_MAX_NONC: max_nonc_reg <= cfg_data[CFG_LIM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == S_FINISH && wb_reg)
            begin
                ring_head_reg[sess_reg]  <= work_head_reg;
                ring_count_reg[sess_reg] <= work_count_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
            item_reg <= req_item;
        sess_reg       <= sess_next;
        work_head_reg  <= work_head_next;
        work_count_reg <= work_count_next;
        idx_reg        <= idx_next;
        dec_reg        <= dec_next;
        if (rsp_load)
        begin
            rsp_item_reg.accepted <= (dec_reg == DEC_OK);
            rsp_item_reg.decision <= dec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            nonce_mem[wr_addr] <= nonce_v;
            stamp_mem[wr_addr] <= created_v;
        end
        rd_nonce_reg <= nonce_mem[rd_addr];
        rd_stamp_reg <= stamp_mem[rd_addr];
    end

    `NRG_ASSERT_NEXT(a_accept_to_pre, clk, rst_n, req_valid && !req_stall, state_reg == S_PRE)
    `NRG_ASSERT_NOW(a_count_bound, clk, rst_n, state_reg == S_FINISH && wb_reg,
        32'(work_count_reg) <= 32'(NONCE_DEPTH))
    `NRG_ASSERT_NOW(a_search_idx, clk, rst_n, state_reg == S_SEARCH, idx_reg <= work_count_reg)
    `NRG_ASSERT_NOW(a_rsp_from_finish, clk, rst_n, $rose(rsp_valid_reg),
        $past(state_reg == S_FINISH))
    `NRG_ASSERT_NOW(a_ok_keeps_limit, clk, rst_n,
        state_reg == S_FINISH && dec_reg == DEC_OK && item_reg.req_type == REQ_CHECK,
        work_count_reg <= lim && work_count_reg != '0)

endmodule
